[sv/assert_macros.svh]
// assertion macros shared by the mapper modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/smm_pkg.sv]
// types and codes shared by the serial bank switch mapper
package smm_pkg;

   typedef enum logic [1:0] {
      KIND_CPU_RD = 2'd0,
      KIND_CPU_WR = 2'd1,
      KIND_PPU_RD = 2'd2,
      KIND_PPU_WR = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      TGT_NONE      = 3'd0,
      TGT_PRG_ROM   = 3'd1,
      TGT_PRG_RAM   = 3'd2,
      TGT_CHR       = 3'd3,
      TGT_NAMETABLE = 3'd4
   } target_type;

   typedef enum logic [1:0] {
      CSR_BOARD_VARIANT  = 2'd0,
      CSR_PRG_BANK_COUNT = 2'd1,
      CSR_PRG_RAM_BYTES  = 2'd2,
      CSR_CHR_IS_RAM     = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      REG_CONTROL  = 2'd0,
      REG_CHR_LOW  = 2'd1,
      REG_CHR_HIGH = 2'd2,
      REG_PRG      = 2'd3
   } bank_reg_sel_type;

   localparam logic [2:0] BOARD_RAM_16K = 3'd2;
   localparam logic [2:0] BOARD_BIG_8K  = 3'd3;
   localparam logic [2:0] BOARD_BIG_32K = 3'd4;

   localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
   localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;

   localparam logic [1:0] MIR_ONE_LOW    = 2'd0;
   localparam logic [1:0] MIR_ONE_HIGH   = 2'd1;
   localparam logic [1:0] MIR_VERTICAL   = 2'd2;
   localparam logic [1:0] MIR_HORIZONTAL = 2'd3;

   localparam logic [4:0] SHIFT_RESET     = 5'h10;
   localparam logic [4:0] CONTROL_RESET   = 5'h0C;
   localparam logic [5:0] PRG_COUNT_RESET = 6'd2;

   typedef struct packed {
      logic [2:0]  board_variant;
      logic [5:0]  prg_bank_count;
      logic [15:0] prg_ram_bytes;
      logic        chr_is_ram;
   } cfg_type;

   typedef struct packed {
      logic [4:0] control;
      logic [4:0] chr_low;
      logic [4:0] chr_high;
      logic [4:0] prg;
   } bank_regs_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] address;
      logic [7:0]  write_data;
   } access_type;

   typedef struct packed {
      target_type  target;
      logic [18:0] mem_address;
      logic        write_enable;
      logic [7:0]  store_byte;
   } result_type;

endpackage

[sv/smm_state.sv]
// configuration registers, serial load shifter and bank registers
module smm_state (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [1:0]             csr_index,
   input  logic [15:0]            csr_data,
   input  logic                   update,
   input  smm_pkg::access_type    acc,
   output smm_pkg::cfg_type       cfg,
   output smm_pkg::bank_regs_type regs
);
   import smm_pkg::*;
   `include "assert_macros.svh"

   cfg_type       cfg_ff, cfg_in;
   bank_regs_type regs_ff, regs_in;
   logic [4:0]    shifter_ff, shifter_in;
   logic [4:0]    shifted;
   logic          serial_wr;

   assign serial_wr = update && (kind_type'(acc.kind) == KIND_CPU_WR) && acc.address[15];
   assign shifted   = {acc.write_data[0], shifter_ff[4:1]};

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_BOARD_VARIANT:  cfg_in.board_variant  = csr_data[2:0];
            CSR_PRG_BANK_COUNT: cfg_in.prg_bank_count = csr_data[5:0];
            CSR_PRG_RAM_BYTES:  cfg_in.prg_ram_bytes  = csr_data;
            CSR_CHR_IS_RAM:     cfg_in.chr_is_ram     = csr_data[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      regs_in    = regs_ff;
      shifter_in = shifter_ff;
      if (serial_wr) begin
         if (acc.write_data[7]) begin
            shifter_in          = SHIFT_RESET;
            regs_in.control     = regs_ff.control | CONTROL_RESET;
         end else if (shifter_ff[0]) begin
            // marker reached bit 0: fifth write commits the value
            shifter_in = SHIFT_RESET;
            unique case (bank_reg_sel_type'(acc.address[14:13]))
               REG_CONTROL:  regs_in.control  = shifted;
               REG_CHR_LOW:  regs_in.chr_low  = shifted;
               REG_CHR_HIGH: regs_in.chr_high = shifted;
               REG_PRG:      regs_in.prg      = shifted;
               default:      regs_in = regs_ff;
            endcase
         end else begin
            shifter_in = shifted;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.board_variant  <= '0;
         cfg_ff.prg_bank_count <= PRG_COUNT_RESET;
         cfg_ff.prg_ram_bytes  <= '0;
         cfg_ff.chr_is_ram     <= 1'b0;
         regs_ff.control       <= CONTROL_RESET;
         regs_ff.chr_low       <= '0;
         regs_ff.chr_high      <= '0;
         regs_ff.prg           <= '0;
         shifter_ff            <= SHIFT_RESET;
      end else begin
         cfg_ff     <= cfg_in;
         regs_ff    <= regs_in;
         shifter_ff <= shifter_in;
      end
   end

   assign cfg  = cfg_ff;
   assign regs = regs_ff;

   // the marker bit is never shifted out without a reload
   `ASSERT_CLK(a_shifter_marker, clock, reset, shifter_ff != 5'd0, "load shifter lost its marker")
   `ASSERT_CLK(a_reset_write_mode, clock, reset,
      serial_wr && acc.write_data[7] |=> regs_ff.control[3:2] == PRG_MODE_FIX_LAST,
      "reset write did not force fixed last bank mode")

endmodule

[sv/smm_xlate.sv]
// address translation of one bus access against the current bank registers
module smm_xlate (
   input  smm_pkg::cfg_type       cfg,
   input  smm_pkg::bank_regs_type regs,
   input  smm_pkg::access_type    acc,
   output smm_pkg::result_type    res
);
   import smm_pkg::*;

   logic        big_board;
   logic        a18;
   logic [4:0]  prg_last;
   logic [4:0]  prg_switch;
   logic [4:0]  prg_sel;
   logic [1:0]  ram_bank;
   logic [14:0] ram_index;
   logic        ram_hit;
   logic [4:0]  chr_sel;
   logic        nt_bit;
   logic        is_wr;
   logic        is_cpu;

   assign big_board  = (cfg.board_variant == BOARD_BIG_8K) ||
                       (cfg.board_variant == BOARD_BIG_32K);
   assign a18        = big_board & regs.chr_low[4];
   assign prg_last   = big_board ? {a18, 4'hF} : 5'(cfg.prg_bank_count - 6'd1);
   assign prg_switch = {a18, regs.prg[3:0]};
   assign is_wr      = acc.kind[0];
   assign is_cpu     = (kind_type'(acc.kind) == KIND_CPU_RD) ||
                       (kind_type'(acc.kind) == KIND_CPU_WR);

   always_comb begin
      case (regs.control[3:2])
         PRG_MODE_FIX_FIRST: prg_sel = acc.address[14] ? prg_switch : {a18, 4'h0};
         PRG_MODE_FIX_LAST:  prg_sel = acc.address[14] ? prg_last : prg_switch;
         default:            prg_sel = {prg_switch[4:1], acc.address[14]};
      endcase
   end

   always_comb begin
      if (cfg.board_variant == BOARD_RAM_16K) begin
         ram_bank = {1'b0, regs.chr_low[3]};
      end else if (cfg.board_variant == BOARD_BIG_32K) begin
         ram_bank = regs.chr_low[3:2];
      end else begin
         ram_bank = 2'd0;
      end
   end

   assign ram_index = {ram_bank, acc.address[12:0]};
   assign ram_hit   = {1'b0, ram_index} < cfg.prg_ram_bytes;

   always_comb begin
      if (regs.control[4]) begin
         chr_sel = acc.address[12] ? regs.chr_high : regs.chr_low;
      end else begin
         chr_sel = {regs.chr_low[4:1], acc.address[12]};
      end
   end

   always_comb begin
      case (regs.control[1:0])
         MIR_ONE_LOW:    nt_bit = 1'b0;
         MIR_ONE_HIGH:   nt_bit = 1'b1;
         MIR_VERTICAL:   nt_bit = acc.address[10];
         MIR_HORIZONTAL: nt_bit = acc.address[11];
         default:        nt_bit = 1'b0;
      endcase
   end

   always_comb begin
      res.target       = TGT_NONE;
      res.mem_address  = '0;
      res.write_enable = 1'b0;
      if (is_cpu) begin
         if (acc.address[15]) begin
            // writes up here feed the serial port and reach no memory
            if (!is_wr) begin
               res.target      = TGT_PRG_ROM;
               res.mem_address = {prg_sel, acc.address[13:0]};
            end
         end else if (acc.address[14:13] == 2'b11) begin
            if (ram_hit) begin
               res.target       = TGT_PRG_RAM;
               res.mem_address  = {4'd0, ram_index};
               res.write_enable = is_wr;
            end
         end
      end else begin
         if (acc.address[15:13] == 3'd0) begin
            res.target       = TGT_CHR;
            res.mem_address  = {2'd0, chr_sel, acc.address[11:0]};
            res.write_enable = is_wr & cfg.chr_is_ram;
         end else if (acc.address < 16'h3F00) begin
            res.target       = TGT_NAMETABLE;
            res.mem_address  = {8'd0, nt_bit, acc.address[9:0]};
            res.write_enable = is_wr;
         end
      end
      res.store_byte = res.write_enable ? acc.write_data : 8'd0;
   end

endmodule

[sv/serial_bank_switch_mapper.sv]
// Serial bank switch mapper: translates one CPU or PPU bus access per clock, while
// rsp_stall is low, into a target memory, byte address and store strobe. An item is
// taken into an input register; when it leaves that register it is translated, the
// bank registers are updated and its result is stored in the result register, which
// presents it on the rsp_ side. Throughput is one item per cycle while rsp_stall is
// low; the result register and input register let the block keep taking items until
// both hold work. Configuration writes through csr_ are always ready and take effect
// for the next translated item; they are to be made only while no item is in flight.
module serial_bank_switch_mapper (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_target,
   output logic [18:0] rsp_mem_address,
   output logic        rsp_write_enable,
   output logic [7:0]  rsp_store_byte,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import smm_pkg::*;
   `include "assert_macros.svh"

   logic          s1_valid_ff, s1_valid_in;
   access_type    s1_ff;
   logic          out_valid_ff, out_valid_in;
   result_type    out_ff;
   result_type    res;
   cfg_type       cfg;
   bank_regs_type regs;
   logic          out_free;
   logic          advance;
   logic          req_take;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   smm_state u_state (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .update    (advance),
      .acc       (s1_ff),
      .cfg       (cfg),
      .regs      (regs)
   );

   smm_xlate u_xlate (
      .cfg  (cfg),
      .regs (regs),
      .acc  (s1_ff),
      .res  (res)
   );

   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_ff.kind       <= req_kind;
         s1_ff.address    <= req_address;
         s1_ff.write_data <= req_write_data;
      end
      if (advance) begin
         out_ff <= res;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_target       = out_ff.target;
   assign rsp_mem_address  = out_ff.mem_address;
   assign rsp_write_enable = out_ff.write_enable;
   assign rsp_store_byte   = out_ff.store_byte;

   `ASSERT_CLK(a_stall_needs_item, clock, reset, req_stall |-> s1_valid_ff,
      "input stalled with an empty input register")
   `ASSERT_CLK(a_we_has_target, clock, reset,
      rsp_valid |-> !(rsp_write_enable && out_ff.target == TGT_NONE),
      "store strobe without a target memory")
   `ASSERT_CLK(a_byte_zero_on_read, clock, reset,
      rsp_valid && !rsp_write_enable |-> rsp_store_byte == 8'd0,
      "store byte not cleared on a non-store item")

endmodule

[tb/smm_translation_checker.sv]
// checker for the mapper: follows the channels, predicts every translation, compares results
module smm_translation_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_write_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_target,
   input  logic [18:0] rsp_mem_address,
   input  logic        rsp_write_enable,
   input  logic [7:0]  rsp_store_byte,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          mismatch_count,
   output int          results_pending
);
   import smm_pkg::*;

   // board setup as last written
   logic [2:0]  variant;
   logic [5:0]  bank_count;
   logic [15:0] ram_limit;
   logic        chr_writable;

   // mapper registers
   logic [4:0]  load_shift;
   logic [4:0]  control_bits;
   logic [4:0]  chr_lo_reg;
   logic [4:0]  chr_hi_reg;
   logic [4:0]  prg_reg;

   result_type  pending_translations[$];

   initial mismatch_count = 0;

   function automatic logic [18:0] prg_rom_offset(input logic [15:0] addr);
      logic       big;
      logic       a18;
      logic [4:0] fixed_last;
      logic [4:0] bank;
      logic [4:0] sel;
      big = (variant == BOARD_BIG_8K) || (variant == BOARD_BIG_32K);
      a18 = big & chr_lo_reg[4];
      // small boards fix the last bank from the bank count, wrapping at 32
      fixed_last = big ? {a18, 4'hF} : 5'(bank_count - 6'd1);
      bank = {a18, prg_reg[3:0]};
      case (control_bits[3:2])
         PRG_MODE_FIX_FIRST: sel = addr[14] ? bank : {a18, 4'h0};
         PRG_MODE_FIX_LAST:  sel = addr[14] ? fixed_last : bank;
         default:            sel = {bank[4:1], addr[14]};
      endcase
      return {sel, addr[13:0]};
   endfunction

   function automatic logic [14:0] prg_ram_offset(input logic [15:0] addr);
      logic [1:0] bank;
      bank = 2'd0;
      if (variant == BOARD_RAM_16K) begin
         bank = {1'b0, chr_lo_reg[3]};
      end else if (variant == BOARD_BIG_32K) begin
         bank = chr_lo_reg[3:2];
      end
      return {bank, addr[12:0]};
   endfunction

   function automatic logic [18:0] chr_offset(input logic [15:0] addr);
      logic [4:0] sel;
      if (control_bits[4]) begin
         sel = addr[12] ? chr_hi_reg : chr_lo_reg;
      end else begin
         sel = {chr_lo_reg[4:1], addr[12]};
      end
      return {2'b00, sel, addr[11:0]};
   endfunction

   function automatic logic [18:0] nametable_offset(input logic [15:0] addr);
      logic page;
      case (control_bits[1:0])
         MIR_ONE_LOW:  page = 1'b0;
         MIR_ONE_HIGH: page = 1'b1;
         MIR_VERTICAL: page = addr[10];
         default:      page = addr[11];
      endcase
      return {8'h00, page, addr[9:0]};
   endfunction

   function automatic void serial_load(input logic [15:0] addr, input logic [7:0] data);
      logic done;
      if (data[7]) begin
         load_shift   = SHIFT_RESET;
         control_bits = control_bits | CONTROL_RESET;
      end else begin
         // the marker bit reaching bit 0 means this is the fifth write
         done = load_shift[0];
         load_shift = {data[0], load_shift[4:1]};
         if (done) begin
            case (bank_reg_sel_type'(addr[14:13]))
               REG_CONTROL:  control_bits = load_shift;
               REG_CHR_LOW:  chr_lo_reg   = load_shift;
               REG_CHR_HIGH: chr_hi_reg   = load_shift;
               default:      prg_reg      = load_shift;
            endcase
            load_shift = SHIFT_RESET;
         end
      end
   endfunction

   function automatic result_type translate_access(input logic [1:0] kind,
                                                   input logic [15:0] addr,
                                                   input logic [7:0] data);
      result_type  r;
      logic [14:0] ram_idx;
      r = '0;
      r.target = TGT_NONE;
      if (kind == KIND_CPU_RD || kind == KIND_CPU_WR) begin
         if (addr[15]) begin
            if (kind == KIND_CPU_WR) begin
               serial_load(addr, data);
            end else begin
               r.target = TGT_PRG_ROM;
               r.mem_address = prg_rom_offset(addr);
            end
         end else if (addr >= 16'h6000) begin
            ram_idx = prg_ram_offset(addr);
            if (ram_idx < ram_limit) begin
               r.target = TGT_PRG_RAM;
               r.mem_address = 19'(ram_idx);
               r.write_enable = (kind == KIND_CPU_WR);
            end
         end
      end else begin
         if (addr < 16'h2000) begin
            r.target = TGT_CHR;
            r.mem_address = chr_offset(addr);
            r.write_enable = (kind == KIND_PPU_WR) && chr_writable;
         end else if (addr < 16'h3F00) begin
            r.target = TGT_NAMETABLE;
            r.mem_address = nametable_offset(addr);
            r.write_enable = (kind == KIND_PPU_WR);
         end
      end
      if (r.write_enable) begin
         r.store_byte = data;
      end
      return r;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         variant      = 3'd0;
         bank_count   = PRG_COUNT_RESET;
         ram_limit    = 16'd0;
         chr_writable = 1'b0;
         load_shift   = SHIFT_RESET;
         control_bits = CONTROL_RESET;
         chr_lo_reg   = 5'd0;
         chr_hi_reg   = 5'd0;
         prg_reg      = 5'd0;
         pending_translations.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_BOARD_VARIANT:  variant      = csr_data[2:0];
               CSR_PRG_BANK_COUNT: bank_count   = csr_data[5:0];
               CSR_PRG_RAM_BYTES:  ram_limit    = csr_data;
               default:            chr_writable = csr_data[0];
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_translations.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual target %0d address 0x%05h",
                        $time, rsp_target, rsp_mem_address);
               mismatch_count++;
            end else begin
               want = pending_translations.pop_front();
               check_field("target", want.target, rsp_target);
               check_field("mem_address", want.mem_address, rsp_mem_address);
               check_field("write_enable", want.write_enable, rsp_write_enable);
               check_field("store_byte", want.store_byte, rsp_store_byte);
            end
         end
         if (req_valid && !req_stall) begin
            pending_translations.push_back(
               translate_access(req_kind, req_address, req_write_data));
         end
      end
      results_pending <= pending_translations.size();
   end

endmodule

[tb/serial_bank_switch_mapper_tb.sv]
// top of the mapper testbench: clock, reset, bus access traffic, board setups and verdict
module serial_bank_switch_mapper_tb;
   import smm_pkg::*;

   localparam logic [7:0] LOAD_RESTART = 8'h80;
   localparam int PHASE_ITEMS = 60;
   localparam int PHASE_COUNT = 9;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_kind = KIND_CPU_RD;
   logic [15:0] req_address = 16'h0000;
   logic [7:0]  req_write_data = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_target;
   logic [18:0] rsp_mem_address;
   logic        rsp_write_enable;
   logic [7:0]  rsp_store_byte;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_BOARD_VARIANT;
   logic [15:0] csr_data = 16'h0000;

   int mismatch_count;
   int results_pending;
   int items_sent = 0;
   bit send_gaps = 1'b0;
   bit rsp_gaps = 1'b0;

   serial_bank_switch_mapper i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_address      (req_address),
      .req_write_data   (req_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_target       (rsp_target),
      .rsp_mem_address  (rsp_mem_address),
      .rsp_write_enable (rsp_write_enable),
      .rsp_store_byte   (rsp_store_byte),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   smm_translation_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_address      (req_address),
      .req_write_data   (req_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_target       (rsp_target),
      .rsp_mem_address  (rsp_mem_address),
      .rsp_write_enable (rsp_write_enable),
      .rsp_store_byte   (rsp_store_byte),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .mismatch_count   (mismatch_count),
      .results_pending  (results_pending)
   );

   always #5 clock = ~clock;

   // receiver back-pressure in bursts
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_gaps && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

   task automatic send_access(input logic [1:0] kind, input logic [15:0] addr,
                              input logic [7:0] data);
      if (send_gaps && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_address    <= addr;
      req_write_data <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // hold off the sender until every result is back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_config(input logic [15:0] variant_word, input logic [15:0] count_word,
                             input logic [15:0] ram_word, input logic [15:0] chr_word);
      csr_index_type order[4];
      logic [15:0]   words[4];
      order = '{CSR_BOARD_VARIANT, CSR_PRG_BANK_COUNT, CSR_PRG_RAM_BYTES, CSR_CHR_IS_RAM};
      words = '{variant_word, count_word, ram_word, chr_word};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= order[i];
         csr_data  <= words[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // five serial writes, lsb first, into the register picked by the last address
   task automatic load_reg(input bank_reg_sel_type which, input logic [4:0] value);
      for (int i = 0; i < 5; i++) begin
         send_access(KIND_CPU_WR, {1'b1, which, 13'($urandom)},
                     {1'b0, 6'($urandom), value[i]});
      end
   endtask

   task automatic random_load();
      bank_reg_sel_type which;
      int               n;
      which = bank_reg_sel_type'($urandom_range(0, 3));
      if ($urandom_range(0, 3) == 0) begin
         send_access(KIND_CPU_WR, {1'b1, 15'($urandom)}, LOAD_RESTART | 8'($urandom));
      end
      if ($urandom_range(0, 5) == 0) begin
         // broken sequence: a few writes, maybe cut short by a restart
         n = $urandom_range(1, 4);
         repeat (n) send_access(KIND_CPU_WR, {1'b1, 15'($urandom)}, {1'b0, 7'($urandom)});
         if ($urandom_range(0, 1) == 1) begin
            send_access(KIND_CPU_WR, {1'b1, 15'($urandom)}, LOAD_RESTART | 8'($urandom));
         end
      end else begin
         load_reg(which, 5'($urandom));
      end
   endtask

   task automatic random_access();
      logic [1:0]  kind;
      logic [15:0] addr;
      kind = 2'($urandom);
      if (kind == KIND_CPU_RD || kind == KIND_CPU_WR) begin
         case ($urandom_range(0, 3))
            0:       addr = {3'b011, 13'($urandom)};
            1, 2:    addr = {1'b1, 15'($urandom)};
            default: addr = 16'($urandom);
         endcase
      end else begin
         case ($urandom_range(0, 3))
            0, 1:    addr = {3'b000, 13'($urandom)};
            2:       addr = 16'h2000 + 16'($urandom_range(0, 16'h1EFF));
            default: addr = 16'($urandom);
         endcase
      end
      send_access(kind, addr, 8'($urandom));
   endtask

   initial begin
      int start;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      send_gaps <= 1'b1;
      rsp_gaps  <= 1'b1;

      // directed: board as after reset, prg fixed-last mode
      send_access(KIND_CPU_RD, 16'h0000, 8'h00);
      send_access(KIND_CPU_WR, 16'h5FFF, 8'hFF);
      send_access(KIND_CPU_RD, 16'h6000, 8'h00);
      send_access(KIND_CPU_WR, 16'h7FFF, 8'hFF);
      send_access(KIND_CPU_RD, 16'h8000, 8'h00);
      send_access(KIND_CPU_RD, 16'hBFFF, 8'h00);
      send_access(KIND_CPU_RD, 16'hFFFF, 8'hFF);
      send_access(KIND_PPU_RD, 16'h0000, 8'h00);
      send_access(KIND_PPU_WR, 16'h1FFF, 8'hA5);
      send_access(KIND_PPU_RD, 16'h2000, 8'h00);
      send_access(KIND_PPU_WR, 16'h3EFF, 8'h5A);
      send_access(KIND_PPU_RD, 16'h3F00, 8'h00);
      send_access(KIND_PPU_WR, 16'hFFFF, 8'hFF);
      // 4 KB chr, 32 KB prg, vertical mirroring
      load_reg(REG_CONTROL, 5'b10010);
      send_access(KIND_CPU_RD, 16'hC000, 8'h00);
      send_access(KIND_PPU_RD, 16'h1000, 8'h00);
      send_access(KIND_CPU_WR, 16'hE000, LOAD_RESTART);
      send_access(KIND_CPU_RD, 16'hFFFF, 8'h00);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         drain_results();
         case (p)
            0: set_config(16'd0, 16'd2, 16'h0000, 16'd0);
            1: set_config(16'd1, 16'd16, 16'h2000, 16'd1);
            2: set_config(16'd2, 16'd8, 16'h4000, 16'd0);
            3: set_config(16'd3, 16'd32, 16'h2000, 16'd1);
            4: set_config(16'd4, 16'd32, 16'h8000, 16'd1);
            5: set_config(16'd4, 16'd1, 16'h4000, 16'd0);
            // unknown variant, bank count masked to zero so the last bank is 31
            6: set_config(16'hFFFF, 16'hFFC0, 16'hFFFF, 16'hFFFE);
            default: set_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
         endcase
         send_gaps <= (p != PHASE_COUNT - 1) && ($urandom_range(0, 2) != 0);
         rsp_gaps  <= (p != PHASE_COUNT - 1) && ($urandom_range(0, 2) != 0);
         start = items_sent;
         while (items_sent - start < PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 25) begin
               random_load();
            end else begin
               random_access();
            end
         end
      end

      drain_results();
      if (mismatch_count == 0 && results_pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
